@@ design/rraes_pkg.sv @@
// Shared types, constants and AES helper functions for the reduced-round AES byte probe.
package rraes_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [127:0] t_block;

    localparam int unsigned SEL_W = 36;
    localparam int unsigned ROUND_W = 4;
    localparam int unsigned PADDR_W = 6;

    typedef enum logic [2:0] {
        REG_KEY_LOW   = 3'd0,
        REG_KEY_HIGH  = 3'd1,
        REG_BASE_LOW  = 3'd2,
        REG_BASE_HIGH = 3'd3,
        REG_ROUNDS    = 3'd4,
        REG_IN_SEL    = 3'd5,
        REG_OUT_SEL   = 3'd6,
        REG_NONE      = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [ROUND_W-1:0] rounds;
        logic [SEL_W-1:0]   out_sel;
    } t_ctl;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam t_byte RCON [10] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    function automatic t_byte xtime(input t_byte a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_byte get_byte(input t_block b, input logic [3:0] i);
        return b[8*i +: 8];
    endfunction

    // Next round key; rcon_idx selects the round constant.
    function automatic t_block next_key(input t_block rk, input logic [3:0] rcon_idx);
        t_block o;
        t_byte t [4];
        t[0] = SBOX[rk[8*13 +: 8]] ^ RCON[rcon_idx];
        t[1] = SBOX[rk[8*14 +: 8]];
        t[2] = SBOX[rk[8*15 +: 8]];
        t[3] = SBOX[rk[8*12 +: 8]];
        o = rk;
        for (int i = 0; i < 4; i++) o[8*i +: 8] = rk[8*i +: 8] ^ t[i];
        for (int i = 4; i < 16; i++) o[8*i +: 8] = rk[8*i +: 8] ^ o[8*(i-4) +: 8];
        return o;
    endfunction

    function automatic t_block aes_round(input t_block s, input t_block rk, input logic mix);
        t_block t;
        t_byte a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r + 4*((c+r) & 3)) +: 8]];
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[8*(4*c) +: 8];
                a1 = t[8*(4*c+1) +: 8];
                a2 = t[8*(4*c+2) +: 8];
                a3 = t[8*(4*c+3) +: 8];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
                t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
                t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        return t ^ rk;
    endfunction

    function automatic logic [3:0] clamp_count(input logic [3:0] n, input logic [3:0] lim);
        return (n > lim) ? lim : n;
    endfunction

endpackage

@@ design/rraes_cfg.sv @@
// APB register file holding key, base block, round count and byte selects.
module rraes_cfg
    import rraes_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output t_block             o_key,
    output t_block             o_base,
    output logic [ROUND_W-1:0] o_rounds,
    output logic [SEL_W-1:0]   o_in_sel,
    output logic [SEL_W-1:0]   o_out_sel
);
    logic [63:0]        r_key_lo, r_key_hi, r_base_lo, r_base_hi;
    logic [ROUND_W-1:0] r_rounds;
    logic [SEL_W-1:0]   r_in_sel, r_out_sel;
    t_reg_idx           w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo  <= '0;
            r_key_hi  <= '0;
            r_base_lo <= '0;
            r_base_hi <= '0;
            r_rounds  <= ROUND_W'(10);
            r_in_sel  <= '0;
            r_out_sel <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KEY_LOW:   r_key_lo  <= pwdata;
                REG_KEY_HIGH:  r_key_hi  <= pwdata;
                REG_BASE_LOW:  r_base_lo <= pwdata;
                REG_BASE_HIGH: r_base_hi <= pwdata;
                REG_ROUNDS:    r_rounds  <= pwdata[ROUND_W-1:0];
                REG_IN_SEL:    r_in_sel  <= pwdata[SEL_W-1:0];
                REG_OUT_SEL:   r_out_sel <= pwdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_KEY_LOW:   prdata = r_key_lo;
            REG_KEY_HIGH:  prdata = r_key_hi;
            REG_BASE_LOW:  prdata = r_base_lo;
            REG_BASE_HIGH: prdata = r_base_hi;
            REG_ROUNDS:    prdata = {60'd0, r_rounds};
            REG_IN_SEL:    prdata = {28'd0, r_in_sel};
            REG_OUT_SEL:   prdata = {28'd0, r_out_sel};
            default:       prdata = '0;
        endcase
    end

    assign o_key     = {r_key_hi, r_key_lo};
    assign o_base    = {r_base_hi, r_base_lo};
    assign o_rounds  = r_rounds;
    assign o_in_sel  = r_in_sel;
    assign o_out_sel = r_out_sel;
endmodule

@@ design/rraes_round.sv @@
// One pipelined AES round stage: round function plus next round key.
module rraes_round
    import rraes_pkg::*;
#(
    parameter int unsigned RoundIdx = 1
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_block i_state,
    input  t_block i_key,
    input  t_ctl   i_ctl,
    output logic   o_valid,
    output t_block o_state,
    output t_block o_key,
    output t_ctl   o_ctl
);
    localparam logic [3:0] RIDX  = 4'(RoundIdx);
    localparam logic [3:0] RCIDX = 4'(RoundIdx - 1);

    logic   r_valid;
    t_block r_state, r_key;
    t_ctl   r_ctl;
    t_block n_key, n_state;
    logic   w_active;

    assign n_key    = next_key(i_key, RCIDX);
    // Rounds beyond the configured count pass the state through.
    assign w_active = (RIDX <= i_ctl.rounds);
    assign n_state  = w_active ? aes_round(i_state, n_key, RIDX < i_ctl.rounds) : i_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (i_en) r_valid <= i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
            r_ctl   <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_ctl   = r_ctl;
endmodule

@@ design/reduced_round_aes128_byte_probe_core.sv @@
// Top level of the reduced-round AES-128 byte probe pipeline.
// Accepts one request per clock unless the output stalls, and returns one
// result per request, in order. One stage injects bytes and adds the key,
// one stage per AES round (unused rounds pass through), one stage gathers the
// output bytes. A stall on the output freezes the whole pipeline. Configuration
// must only change while the pipeline is empty.
module reduced_round_aes128_byte_probe_core
    import rraes_pkg::*;
#(
    parameter int unsigned MAX_ROUNDS = 10,
    parameter int unsigned MAX_SELECTED_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [63:0]        i_active_bytes,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_extracted_bytes
);
    localparam logic [3:0] MAXR = 4'(MAX_ROUNDS);
    localparam logic [3:0] MAXB = 4'(MAX_SELECTED_BYTES);

    t_block             w_key, w_base;
    logic [ROUND_W-1:0] w_rounds;
    logic [SEL_W-1:0]   w_in_sel, w_out_sel;
    logic               w_en;

    rraes_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .o_key(w_key), .o_base(w_base), .o_rounds(w_rounds),
        .o_in_sel(w_in_sel), .o_out_sel(w_out_sel)
    );

    // Whole pipeline advances unless the output holds an untaken result.
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // Stage 0: inject and add key.
    t_block n_blk;
    t_ctl   n_ctl;
    logic [3:0] w_nin;
    always_comb begin
        n_blk = w_base;
        w_nin = clamp_count(w_in_sel[3:0], MAXB);
        for (int i = 0; i < 8; i++)
            if (4'(i) < w_nin) n_blk[8*w_in_sel[4*i+4 +: 4] +: 8] = i_active_bytes[8*i +: 8];
        n_blk = n_blk ^ w_key;
        n_ctl.rounds  = (w_rounds == 4'd0) ? 4'd1 : ((w_rounds > MAXR) ? MAXR : w_rounds);
        n_ctl.out_sel = w_out_sel;
    end

    logic   v [MAX_ROUNDS+1];
    t_block s [MAX_ROUNDS+1];
    t_block k [MAX_ROUNDS+1];
    t_ctl   c [MAX_ROUNDS+1];
    logic   r_v0;
    t_block r_s0, r_k0;
    t_ctl   r_c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (w_en) r_v0 <= i_valid;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= n_blk;
            r_k0 <= w_key;
            r_c0 <= n_ctl;
        end
    end
    assign v[0] = r_v0;
    assign s[0] = r_s0;
    assign k[0] = r_k0;
    assign c[0] = r_c0;

    for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
        rraes_round #(.RoundIdx(g)) u_round (
            .i_clk, .i_rst_n, .i_en(w_en),
            .i_valid(v[g-1]), .i_state(s[g-1]), .i_key(k[g-1]), .i_ctl(c[g-1]),
            .o_valid(v[g]), .o_state(s[g]), .o_key(k[g]), .o_ctl(c[g])
        );
    end

    // Output stage: gather bytes.
    logic        r_ovalid;
    logic [63:0] r_out, n_out;
    logic [3:0]  w_nout;
    always_comb begin
        n_out  = '0;
        w_nout = clamp_count(c[MAX_ROUNDS].out_sel[3:0], MAXB);
        for (int i = 0; i < 8; i++)
            if (4'(i) < w_nout)
                n_out[8*i +: 8] = get_byte(s[MAX_ROUNDS], c[MAX_ROUNDS].out_sel[4*i+4 +: 4]);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_en) r_ovalid <= v[MAX_ROUNDS];
    end
    always_ff @(posedge i_clk) begin
        if (w_en) r_out <= n_out;
    end
    assign o_valid           = r_ovalid;
    assign o_extracted_bytes = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_extracted_bytes))
        else $error("result lost under stall");
    a_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && v[MAX_ROUNDS] |=> o_valid)
        else $error("last round result not forwarded");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_v0)
        else $error("accepted request not captured");
endmodule
